[src/rwlk_pkg.sv]
// Shared types, codes and constants of the reader/writer lock arbiter.
package rwlk_pkg;

  localparam int unsigned DefThreads    = 16;
  localparam int unsigned DefGroupSlots = 16;

  // Field widths of the request and result formats, and counter widths and limits.
  localparam int unsigned ThreadIdW = 4;
  localparam int unsigned SlotOutW  = 4;
  localparam int unsigned MemberW   = 5;
  localparam int unsigned NestW     = 8;
  localparam logic [MemberW-1:0] MemberMax = '1;
  localparam logic [NestW-1:0]   NestMax   = '1;

  localparam logic OpAcquire = 1'b0;
  localparam logic OpRelease = 1'b1;

  typedef enum logic [2:0] {
    StGranted   = 3'd0,
    StQueued    = 3'd1,
    StNested    = 3'd2,
    StRecursive = 3'd3,
    StReleased  = 3'd4,
    StNotHolder = 3'd5,
    StCapacity  = 3'd6
  } status_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic capture;
    logic rd_first;
    logic rd_group;
    logic execute;
    logic latch_wake;
    logic load_out;
  } cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic wake_needed;
    logic out_busy;
  } sts_t;

endpackage

[src/rwlk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rwlk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/rwlk_dp.sv]
// Datapath of the lock arbiter: thread and group tables, ring pointers, result registers.
module rwlk_dp #(
  parameter int unsigned THREADS     = rwlk_pkg::DefThreads,
  parameter int unsigned GROUP_SLOTS = rwlk_pkg::DefGroupSlots
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rwlk_pkg::cmd_t                     cmd_i,
  output rwlk_pkg::sts_t                     sts_o,
  input  logic                               op_i,
  input  logic [rwlk_pkg::ThreadIdW-1:0]     thread_id_i,
  input  logic                               access_i,
  input  logic                               m_tready_i,
  output logic                               m_tvalid_o,
  output rwlk_pkg::status_e                  m_status_o,
  output logic [rwlk_pkg::SlotOutW-1:0]      m_slot_o,
  output logic                               m_wv_o,
  output logic [rwlk_pkg::SlotOutW-1:0]      m_ws_o,
  output logic                               m_ww_o
);
  import rwlk_pkg::*;

  localparam int unsigned TW  = $clog2(THREADS);
  localparam int unsigned SW  = $clog2(GROUP_SLOTS);
  localparam int unsigned CW  = $clog2(GROUP_SLOTS + 1);
  localparam int unsigned RW  = SW + 2;
  localparam int unsigned TDW = NestW + SW;
  localparam int unsigned GDW = MemberW + 1;

  localparam logic [RW-1:0] RingSize = RW'(GROUP_SLOTS);
  localparam logic [SW-1:0] LastSlot = SW'(GROUP_SLOTS - 1);
  localparam logic [CW-1:0] RingFull = CW'(GROUP_SLOTS);

  // Captured request.
  logic                 op_q, wr_q;
  logic [ThreadIdW-1:0] thr_q;

  // Ring state.
  logic [SW-1:0]      head_q, head_d;
  logic [CW-1:0]      inuse_q, inuse_d;
  logic [THREADS-1:0] holds_q, holds_d;

  // Youngest group, latched as the second group read is issued.
  logic               tail_kind_q;
  logic [MemberW-1:0] tail_mem_q;

  // Result being built.
  status_e       res_status_q;
  logic [SW-1:0] res_slot_q, res_ws_q;
  logic          res_wv_q, res_ww_q;

  // Output register.
  logic                out_valid_q;
  status_e             out_status_q;
  logic [SlotOutW-1:0] out_slot_q, out_ws_q;
  logic                out_wv_q, out_ww_q;

  logic [TW+3:0] tid_ext;
  logic [TW-1:0] tidx;
  logic          in_range, held;

  logic [TDW-1:0] thr_rdata, thr_wdata;
  logic           thr_we;
  logic [SW-1:0]  t_grp;
  logic [NestW-1:0] t_nest;

  logic [GDW-1:0] grp_rdata, grp_wdata;
  logic           grp_we, grp_re;
  logic [SW-1:0]  grp_waddr, grp_raddr;
  logic           g_kind;
  logic [MemberW-1:0] g_mem;

  logic [RW-1:0] ring_sum, new_slot_w;
  logic [SW-1:0] new_slot, tail_slot, head_next;

  // Decision of the execute step.
  status_e       ex_status;
  logic [SW-1:0] ex_slot;
  logic          ex_wake, holds_set, holds_clr, head_adv, inuse_inc, inuse_dec;
  logic          need_new, join_ok;
  logic [NestW-1:0]   nest_new;
  logic [SW-1:0]      grp_new;
  logic [MemberW-1:0] mem_new, mem_dec;

  logic [SW+3:0] res_slot_ext, res_ws_ext;

  assign tid_ext  = {{TW{1'b0}}, thr_q};
  assign tidx     = tid_ext[TW-1:0];
  assign in_range = (tid_ext < (TW+4)'(THREADS));
  assign held     = in_range & holds_q[tidx];

  assign t_grp  = thr_rdata[SW-1:0];
  assign t_nest = thr_rdata[TDW-1:SW];
  assign g_kind = grp_rdata[MemberW];
  assign g_mem  = grp_rdata[MemberW-1:0];

  assign ring_sum   = RW'(head_q) + RW'(inuse_q);
  assign new_slot_w = (ring_sum >= RingSize) ? (ring_sum - RingSize) : ring_sum;
  assign new_slot   = new_slot_w[SW-1:0];
  assign tail_slot  = (new_slot == '0) ? LastSlot : (new_slot - 1'b1);
  assign head_next  = (head_q == LastSlot) ? '0 : (head_q + 1'b1);

  rwlk_ram #(
    .WIDTH (TDW),
    .DEPTH (THREADS)
  ) u_thr_ram (
    .clk_i   (clk_i),
    .we_i    (thr_we & cmd_i.execute),
    .waddr_i (tidx),
    .wdata_i (thr_wdata),
    .re_i    (cmd_i.rd_first),
    .raddr_i (tidx),
    .rdata_o (thr_rdata)
  );

  assign grp_re    = cmd_i.rd_first | cmd_i.rd_group | (cmd_i.execute & ex_wake);
  assign grp_raddr = cmd_i.rd_first ? tail_slot : (cmd_i.rd_group ? t_grp : head_next);

  rwlk_ram #(
    .WIDTH (GDW),
    .DEPTH (GROUP_SLOTS)
  ) u_grp_ram (
    .clk_i   (clk_i),
    .we_i    (grp_we & cmd_i.execute),
    .waddr_i (grp_waddr),
    .wdata_i (grp_wdata),
    .re_i    (grp_re),
    .raddr_i (grp_raddr),
    .rdata_o (grp_rdata)
  );

  assign thr_wdata = {nest_new, grp_new};

  always_comb begin
    ex_status = StCapacity;
    ex_slot   = '0;
    ex_wake   = 1'b0;
    holds_set = 1'b0;
    holds_clr = 1'b0;
    head_adv  = 1'b0;
    inuse_inc = 1'b0;
    inuse_dec = 1'b0;
    thr_we    = 1'b0;
    nest_new  = '0;
    grp_new   = t_grp;
    grp_we    = 1'b0;
    grp_waddr = t_grp;
    grp_wdata = '0;
    need_new  = wr_q | (inuse_q == '0) | tail_kind_q;
    join_ok   = 1'b0;
    mem_new   = '0;
    mem_dec   = (g_mem != '0) ? (g_mem - 1'b1) : g_mem;
    if (!in_range) begin
      ex_status = (op_q == OpRelease) ? StNotHolder : StCapacity;
    end else if (op_q == OpAcquire) begin
      if (held) begin
        if (wr_q || g_kind) begin
          ex_status = StRecursive;
          ex_slot   = t_grp;
        end else if (t_nest == NestMax) begin
          ex_status = StCapacity;
        end else begin
          thr_we    = 1'b1;
          nest_new  = t_nest + 1'b1;
          ex_status = StNested;
          ex_slot   = t_grp;
        end
      end else begin
        if (need_new) begin
          if (inuse_q != RingFull) begin
            grp_we    = 1'b1;
            grp_waddr = new_slot;
            mem_new   = MemberW'(1);
            grp_wdata = {wr_q, mem_new};
            inuse_inc = 1'b1;
            join_ok   = 1'b1;
            ex_slot   = new_slot;
          end
        end else if (tail_mem_q != MemberMax) begin
          grp_we    = 1'b1;
          grp_waddr = tail_slot;
          mem_new   = tail_mem_q + 1'b1;
          grp_wdata = {1'b0, mem_new};
          join_ok   = 1'b1;
          ex_slot   = tail_slot;
        end
        if (join_ok) begin
          holds_set = 1'b1;
          thr_we    = 1'b1;
          nest_new  = '0;
          grp_new   = ex_slot;
          ex_status = (ex_slot == head_q) ? StGranted : StQueued;
        end
      end
    end else begin
      if (!held || (t_grp != head_q) || (inuse_q == '0)) begin
        ex_status = StNotHolder;
      end else if (t_nest != '0) begin
        thr_we    = 1'b1;
        nest_new  = t_nest - 1'b1;
        ex_status = StReleased;
        ex_slot   = t_grp;
      end else begin
        holds_clr = 1'b1;
        grp_we    = 1'b1;
        grp_waddr = t_grp;
        grp_wdata = {g_kind, mem_dec};
        ex_status = StReleased;
        ex_slot   = t_grp;
        if (mem_dec == '0) begin
          head_adv  = 1'b1;
          inuse_dec = 1'b1;
          ex_wake   = (inuse_q != CW'(1));
        end
      end
    end
  end

  always_comb begin
    holds_d = holds_q;
    head_d  = head_q;
    inuse_d = inuse_q;
    if (cmd_i.execute) begin
      if (holds_set) begin
        holds_d[tidx] = 1'b1;
      end
      if (holds_clr) begin
        holds_d[tidx] = 1'b0;
      end
      if (head_adv) begin
        head_d = head_next;
      end
      if (inuse_inc) begin
        inuse_d = inuse_q + 1'b1;
      end
      if (inuse_dec) begin
        inuse_d = inuse_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      inuse_q     <= '0;
      holds_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      inuse_q <= inuse_d;
      holds_q <= holds_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_slot_ext = {4'b0, res_slot_q};
  assign res_ws_ext   = {4'b0, res_ws_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      thr_q <= thread_id_i;
      wr_q  <= access_i;
    end
    if (cmd_i.rd_group) begin
      tail_kind_q <= g_kind;
      tail_mem_q  <= g_mem;
    end
    if (cmd_i.execute) begin
      res_status_q <= ex_status;
      res_slot_q   <= ex_slot;
      res_wv_q     <= ex_wake;
      res_ws_q     <= ex_wake ? head_next : '0;
      res_ww_q     <= 1'b0;
    end
    if (cmd_i.latch_wake) begin
      res_ww_q <= g_kind;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_ext[SlotOutW-1:0];
      out_wv_q     <= res_wv_q;
      out_ws_q     <= res_ws_ext[SlotOutW-1:0];
      out_ww_q     <= res_ww_q;
    end
  end

  assign sts_o.wake_needed = ex_wake;
  assign sts_o.out_busy    = out_valid_q & ~m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_status_o = out_status_q;
  assign m_slot_o   = out_slot_q;
  assign m_wv_o     = out_wv_q;
  assign m_ws_o     = out_ws_q;
  assign m_ww_o     = out_ww_q;

endmodule

[src/rwlk_ctrl.sv]
// Sequencer of the lock arbiter: steps one request through its table reads and update.
module rwlk_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  rwlk_pkg::sts_t sts_i,
  output rwlk_pkg::cmd_t cmd_o
);
  import rwlk_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_THR,
    S_RD_GRP,
    S_EXEC,
    S_WAKE,
    S_DONE
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   accept;

  assign accept = s_tvalid_i & ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_RD_THR;
            ready_q <= 1'b0;
          end
        end
        S_RD_THR: state_q <= S_RD_GRP;
        S_RD_GRP: state_q <= S_EXEC;
        S_EXEC:   state_q <= sts_i.wake_needed ? S_WAKE : S_DONE;
        S_WAKE:   state_q <= S_DONE;
        S_DONE: begin
          if (!sts_i.out_busy) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = accept;
    unique case (state_q)
      S_IDLE:   ;
      S_RD_THR: cmd_o.rd_first   = 1'b1;
      S_RD_GRP: cmd_o.rd_group   = 1'b1;
      S_EXEC:   cmd_o.execute    = 1'b1;
      S_WAKE:   cmd_o.latch_wake = 1'b1;
      S_DONE:   cmd_o.load_out   = ~sts_i.out_busy;
      default:  ;
    endcase
  end

  assign s_tready_o = ready_q;

endmodule

[src/fifo_reader_writer_lock_arbiter.sv]
// Top level of the FIFO-fair reader/writer lock arbiter.
// A result beat is loaded into the output register after its request beat has passed the
// thread read, group read and update steps, plus the wake step when a release hands the lock on.
// Requests are taken one at a time, each once the previous result is in the output register,
// which a stalled beat holds off; three dependent reads share the group table's single read port.
// Reset clears the ring pointers, the holder flags and the handshake state at once;
// the group and thread tables need no clearing: no entry's data is used before it is written.
module fifo_reader_writer_lock_arbiter #(
  parameter int unsigned THREADS     = rwlk_pkg::DefThreads,
  parameter int unsigned GROUP_SLOTS = rwlk_pkg::DefGroupSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [3:0] thread_id, [4] access_type, [7:5] zero
  input  logic [0:0]  s_axis_tuser_i,   // [0] operation
  // Result channel.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [3:0] group_slot, [4] woken_valid,
                                        // [8:5] woken_slot, [9] woken_is_write, [15:10] zero
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);
  import rwlk_pkg::*;

  // The sequencer and the datapath talk only through these two bundles.
  cmd_t cmd;
  sts_t sts;

  status_e             m_status;
  logic [SlotOutW-1:0] m_slot, m_ws;
  logic                m_wv, m_ww;

  // The sequencer takes one request at a time and walks it through a fixed
  // series of steps: read the thread entry and the youngest group, read the
  // requester's group, apply the update, optionally read the newly granted
  // group, and finally hand the result to the output register.
  rwlk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath keeps the ring of groups, the per-thread tables and the
  // output register. The output register lets a finished beat wait for the
  // consumer while the next request is already taken in.
  rwlk_dp #(
    .THREADS     (THREADS),
    .GROUP_SLOTS (GROUP_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (s_axis_tuser_i[0]),
    .thread_id_i (s_axis_tdata_i[3:0]),
    .access_i    (s_axis_tdata_i[4]),
    .m_tready_i  (m_axis_tready_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_status_o  (m_status),
    .m_slot_o    (m_slot),
    .m_wv_o      (m_wv),
    .m_ws_o      (m_ws),
    .m_ww_o      (m_ww)
  );

  // Pack the result fields, lowest field first, zero filled to whole bytes.
  assign m_axis_tdata_o = {6'b0, m_ww, m_ws, m_wv, m_slot};
  assign m_axis_tuser_o = m_status;

endmodule

[src/rwlk_checker.sv]
// Port-level checks of the lock arbiter and their binding to the top level.
module rwlk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic [0:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);
  import rwlk_pkg::*;

  // One request at a time: the block stops taking beats right after a beat is taken.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while a previous one is in work");

  // A stalled result beat must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // Only a release can hand the lock to the next group.
  a_wake_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[4] |-> m_axis_tuser_o == StReleased)
    else $error("hand-over reported without a release");

  // Hand-over fields read zero when nothing was handed over.
  a_wake_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[4] |-> m_axis_tdata_o[9:5] == 5'b0)
    else $error("hand-over fields set without a hand-over");

endmodule

bind fifo_reader_writer_lock_arbiter rwlk_checker u_rwlk_checker (.*);
